@@ hdl/i64dec_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i64dec_pkg
// Shared types, constants and the binary to BCD step function for the
// signed 64-bit integer to decimal text converter.
// ----------------------------------------------------------------------------
package i64dec_pkg;

	localparam int ValueW       = 64;
	localparam int NumDigits    = 20;
	localparam int BcdW         = 4 * NumDigits;
	localparam int BitsPerStage = 8;
	localparam int DabbleStages = ValueW / BitsPerStage;
	localparam int NumStages    = DabbleStages + 1;
	localparam int CharW        = 6;
	localparam int IdxW         = 5;

	localparam logic [CharW-1:0] CharMinus = 6'd45;
	localparam logic [CharW-1:0] CharZero  = 6'd48;

	typedef struct packed {
		logic              neg;
		logic [BcdW-1:0]   bcd;
		logic [ValueW-1:0] mag;
	} stage_t;

	// Eight shift-and-add-3 steps of the double dabble conversion.
	function automatic stage_t dabble_stage(stage_t d);
		stage_t r;
		r = d;
		for (int k = 0; k < BitsPerStage; k++) begin
			for (int g = 0; g < NumDigits; g++) begin
				if (r.bcd[g*4 +: 4] >= 4'd5) begin
					r.bcd[g*4 +: 4] = r.bcd[g*4 +: 4] + 4'd3;
				end
			end
			r.bcd = {r.bcd[BcdW-2:0], r.mag[ValueW-1]};
			r.mag = {r.mag[ValueW-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

@@ hdl/int64_to_decimal_ascii_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii_unit
// Converts signed 64-bit integers into decimal ASCII text, one character
// per output word, most significant character first.
// ----------------------------------------------------------------------------
// The input channel (value_valid, value_ready, value) takes one signed
// 64-bit integer per word. The output channel (char_valid, char_ready,
// character, is_last) gives one ASCII character per word: a leading '-'
// for negative numbers, then the digits without leading zeros. The last
// character of each number has is_last set.
// A number passes a negation stage and eight double dabble stages of eight
// bits each, then a character serializer.
// The serializer sends one character per cycle while char_ready stays high,
// and loads the next number only once the last character of the current
// number has been sent; this sets the sustained rate. Up to nine
// numbers wait in the conversion stages behind it.
// When the receiver holds char_ready low, the output word holds, no further
// character is sent, full conversion stages stop, and no word is lost.
// Reset clears all valid flags and the serializer; both channels are empty.
// ----------------------------------------------------------------------------
module int64_to_decimal_ascii_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            value_valid,
	output logic                            value_ready,
	input  logic [i64dec_pkg::ValueW-1:0]   value,
	output logic                            char_valid,
	input  logic                            char_ready,
	output logic [i64dec_pkg::CharW-1:0]    character,
	output logic                            is_last
);

	localparam int NS = i64dec_pkg::NumStages;

	i64dec_pkg::stage_t                 data_s [NS];
	logic [NS-1:0]                      vld_s;
	logic [NS:0]                        advance;
	i64dec_pkg::stage_t                 entry;

	logic                               active_q;
	logic                               minus_q;
	logic [i64dec_pkg::BcdW-1:0]        digits_q;
	logic [i64dec_pkg::IdxW-1:0]        idx_q;
	logic                               out_valid_q;
	logic [i64dec_pkg::CharW-1:0]       char_q;
	logic                               last_q;

	logic                               load;
	logic                               emit;
	logic [i64dec_pkg::IdxW-1:0]        msd;
	logic [3:0]                         cur_digit;

	always_comb begin
		entry.neg = value[i64dec_pkg::ValueW-1];
		entry.mag = value[i64dec_pkg::ValueW-1] ? (~value + 64'd1) : value;
		entry.bcd = '0;
	end

	always_comb begin
		advance[NS] = !active_q;
		for (int i = NS - 1; i >= 0; i--) begin
			advance[i] = !vld_s[i] || advance[i+1];
		end
	end

	assign value_ready = advance[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (advance[0]) begin
			vld_s[0] <= value_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance[0] && value_valid) begin
			data_s[0] <= entry;
		end
	end

	for (genvar s = 1; s < NS; s++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else if (advance[s]) begin
				vld_s[s] <= vld_s[s-1];
			end
		end

		always_ff @(posedge clk) begin
			if (advance[s] && vld_s[s-1]) begin
				data_s[s] <= i64dec_pkg::dabble_stage(data_s[s-1]);
			end
		end
	end

	always_comb begin
		msd = '0;
		for (int g = 0; g < i64dec_pkg::NumDigits; g++) begin
			if (data_s[NS-1].bcd[g*4 +: 4] != 4'd0) begin
				msd = i64dec_pkg::IdxW'(g);
			end
		end
	end

	assign load      = vld_s[NS-1] && !active_q;
	assign emit      = active_q && (!out_valid_q || char_ready);
	assign cur_digit = digits_q[idx_q*4 +: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			minus_q     <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				active_q <= 1'b1;
				minus_q  <= data_s[NS-1].neg;
				idx_q    <= msd;
			end else if (emit) begin
				if (minus_q) begin
					minus_q <= 1'b0;
				end else if (idx_q == '0) begin
					active_q <= 1'b0;
				end else begin
					idx_q <= idx_q - 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (char_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digits_q <= data_s[NS-1].bcd;
		end
		if (emit) begin
			if (minus_q) begin
				char_q <= i64dec_pkg::CharMinus;
				last_q <= 1'b0;
			end else begin
				char_q <= i64dec_pkg::CharZero + {2'b00, cur_digit};
				last_q <= (idx_q == '0);
			end
		end
	end

	assign char_valid = out_valid_q;
	assign character  = char_q;
	assign is_last    = last_q;

endmodule
